/* rtl/sscc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared constants for the streaming SCC edge step block.
// ----------------------------------------------------------------------------
package sscc_pkg;
   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
endpackage

/* rtl/streaming_scc_edge_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_scc_edge_step_top
// Semi-streaming SCC step: forest of representatives with parent pointers
// and a representative map, both held in single-port RAMs.
// ----------------------------------------------------------------------------
// Timing: data dependent; a map hop is a read, then a rewrite on
//   compression; a forest hop reads the parent and then walks the map.
//   An edge walks both the forest and the map, a query only the map.
// Throughput: one transaction at a time; busy stays high until the result.
// Reset: a clearing pass writes identity into the map and the dummy
//   root into every parent entry; busy is high during it.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle.
module streaming_scc_edge_step_top
   import sscc_pkg::*;
#(
   parameter int NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [9:0]  req_src_node,
   input  logic [9:0]  req_dst_node,
   output logic        rsp_strobe,
   output logic        rsp_emit_valid,
   output logic [9:0]  rsp_out_src,
   output logic [9:0]  rsp_out_dst,
   output logic        rsp_changed,
   output logic [9:0]  rsp_representative
);
   localparam int AW = $clog2(NODES);
   localparam int NW = $clog2(NODES + 1);
   localparam logic [NW-1:0] ROOT = NW'(NODES);

   // Top-level sequencer states
   localparam logic [4:0] S_CLR   = 5'd0,  S_IDLE  = 5'd1,  S_REP_RD = 5'd2,
                          S_REP_W = 5'd3,  S_CMP_RD= 5'd4,  S_CMP_W  = 5'd5,
                          S_DISP  = 5'd6,  S_UP_RD = 5'd7,  S_UP_W   = 5'd8,
                          S_DONE  = 5'd9,  S_ANC   = 5'd10, S_COL    = 5'd11,
                          S_ATT   = 5'd12, S_DEP   = 5'd13, S_CROSS  = 5'd14,
                          S_MRG   = 5'd15, S_SETP  = 5'd16;
   // Operation phases (what the current hop-walk is for)
   localparam logic [3:0] P_Q = 4'd0, P_U = 4'd1, P_V = 4'd2, P_A1 = 4'd3,
                          P_A2 = 4'd4, P_COL = 4'd5, P_COLN = 4'd6,
                          P_ATT = 4'd7, P_DU = 4'd8, P_DV = 4'd9,
                          P_PV = 4'd10, P_SP = 4'd11;

   logic [4:0]    st_ff, st_in, ret_ff, ret_in;
   logic [3:0]    ph_ff, ph_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [9:0]    d_ff;
   logic [NW-1:0] x_ff, x_in, r_ff, r_in, c_ff, c_in, res_ff, res_in;
   logic [NW-1:0] u_ff, u_in, v_ff, v_in, cur_ff, cur_in, aux_ff, aux_in;
   logic [NW-1:0] du_ff, du_in, dcnt_ff, dcnt_in;
   logic          out_v_ff, out_v_in;
   logic          em_ff, em_in, ch_ff, ch_in;
   logic [9:0]    os_ff, os_in, od_ff, od_in, rp_ff, rp_in;
   logic [AW:0]   hop_ff, hop_in;

   logic          rep_we, par_we;
   logic [AW-1:0] rep_a, par_a;
   logic [AW-1:0] rep_wd;
   logic [NW-1:0] par_wd, par_rd;
   logic [AW-1:0] rep_rd;

   sscc_ram #(.WIDTH(AW), .DEPTH(NODES)) u_rep (
      .clock(clock), .wr_en(rep_we), .addr(rep_a), .wr_data(rep_wd),
      .rd_data(rep_rd));
   sscc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_par (
      .clock(clock), .wr_en(par_we), .addr(par_a), .wr_data(par_wd),
      .rd_data(par_rd));

   logic [NW-1:0] rep_rdx;
   assign rep_rdx = NW'(rep_rd);

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; ph_in = ph_ff; cnt_in = cnt_ff;
      x_in = x_ff; r_in = r_ff; c_in = c_ff; res_in = res_ff;
      u_in = u_ff; v_in = v_ff; cur_in = cur_ff; aux_in = aux_ff;
      du_in = du_ff; dcnt_in = dcnt_ff; hop_in = hop_ff;
      out_v_in = 1'b0; em_in = em_ff; ch_in = ch_ff;
      os_in = os_ff; od_in = od_ff; rp_in = rp_ff;
      rep_we = 1'b0; par_we = 1'b0;
      rep_a = x_ff[AW-1:0]; par_a = r_ff[AW-1:0];
      rep_wd = r_ff[AW-1:0]; par_wd = ROOT;
      unique case (st_ff)
         S_CLR: begin
            // sweep: identity map, dummy-root parents
            rep_we = 1'b1; par_we = 1'b1;
            rep_a = cnt_ff[AW-1:0]; par_a = cnt_ff[AW-1:0];
            rep_wd = cnt_ff[AW-1:0]; par_wd = ROOT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(NODES - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            em_in = 1'b0; ch_in = 1'b0; os_in = '0; od_in = '0; rp_in = '0;
            if (start) begin
               if (req_command == CMD_QUERY) begin
                  if (int'(req_src_node) >= NODES) begin
                     rp_in = req_src_node; st_in = S_DONE;
                  end else begin
                     x_in = NW'(req_src_node); ph_in = P_Q; st_in = S_REP_RD;
                  end
               end else if (int'(req_src_node) >= NODES ||
                            int'(req_dst_node) >= NODES) begin
                  st_in = S_DONE;
               end else begin
                  x_in = NW'(req_src_node); ph_in = P_U; st_in = S_REP_RD;
               end
            end
         end
         // ---- rep_of(x): walk the map, result in res
         S_REP_RD: begin
            if (x_ff >= ROOT) begin
               res_in = ROOT; st_in = S_DISP;
            end else begin
               rep_a = x_ff[AW-1:0]; r_in = x_ff; hop_in = '0;
               st_in = S_REP_W;
            end
         end
         S_REP_W: begin
            rep_a = r_ff[AW-1:0];
            if (rep_rdx == r_ff) begin
               c_in = x_ff; st_in = S_CMP_RD;
            end else begin
               r_in = rep_rdx; hop_in = hop_ff + 1'b1;
               rep_a = rep_rd;
            end
         end
         // ---- compress chain from x to r
         S_CMP_RD: begin
            rep_a = c_ff[AW-1:0];
            if (c_ff == r_ff) begin
               res_in = r_ff; st_in = S_DISP;
            end else begin
               st_in = S_CMP_W;
            end
         end
         S_CMP_W: begin
            rep_we = 1'b1; rep_a = c_ff[AW-1:0]; rep_wd = r_ff[AW-1:0];
            c_in = rep_rdx; st_in = S_CMP_RD;
         end
         // ---- up_of(res): parent read then rep_of
         S_UP_RD: begin
            if (res_ff >= ROOT) begin
               st_in = ret_ff;
            end else begin
               par_a = res_ff[AW-1:0]; st_in = S_UP_W;
            end
         end
         S_UP_W: begin
            x_in = par_rd; st_in = S_REP_RD;
         end
         S_DISP: begin
            unique case (ph_ff)
               P_Q: begin
                  rp_in = 10'(res_ff); st_in = S_DONE;
               end
               P_U: begin
                  u_in = res_ff; x_in = NW'(d_ff); ph_in = P_V;
                  st_in = S_REP_RD;
               end
               P_V: begin
                  v_in = res_ff;
                  if (res_ff == u_ff) st_in = S_DONE;
                  else begin
                     // is u an ancestor of v?
                     cur_in = res_ff; aux_in = u_ff; ph_in = P_A1;
                     hop_in = '0; st_in = S_ANC;
                  end
               end
               P_A1, P_A2: begin
                  cur_in = res_ff; st_in = S_ANC;
               end
               P_COL: begin
                  // nx = up(cur) in res; merge cur into v
                  aux_in = res_ff; st_in = S_MRG;
               end
               P_ATT: begin
                  if (res_ff == ROOT) begin
                     cur_in = u_ff; st_in = S_SETP; ch_in = 1'b1;
                  end else begin
                     cur_in = u_ff; dcnt_in = '0; ph_in = P_DU;
                     st_in = S_DEP;
                  end
               end
               P_DU, P_DV: begin
                  cur_in = res_ff; dcnt_in = dcnt_ff + 1'b1; st_in = S_DEP;
               end
               P_PV: begin
                  em_in = 1'b1; os_in = 10'(res_ff); od_in = 10'(v_ff);
                  ch_in = 1'b1; st_in = S_SETP;
               end
               default: st_in = S_DONE;
            endcase
         end
         S_ANC: begin
            // walk cur up the forest looking for aux
            if (cur_ff == ROOT || hop_ff > (AW+1)'(NODES)) begin
               if (ph_ff == P_A1) begin
                  cur_in = u_ff; aux_in = v_ff; ph_in = P_A2; hop_in = '0;
               end else begin
                  res_in = v_ff; ph_in = P_ATT; ret_in = S_DISP;
                  st_in = S_UP_RD;
               end
            end else if (cur_ff == aux_ff) begin
               if (ph_ff == P_A1) st_in = S_DONE;
               else begin
                  cur_in = u_ff; st_in = S_COL; ch_in = 1'b1;
               end
            end else begin
               hop_in = hop_ff + 1'b1; res_in = cur_ff; ret_in = S_DISP;
               st_in = S_UP_RD;
            end
         end
         S_COL: begin
            if (cur_ff == v_ff || cur_ff == ROOT) st_in = S_DONE;
            else begin
               res_in = cur_ff; ph_in = P_COL; ret_in = S_DISP;
               st_in = S_UP_RD;
            end
         end
         S_MRG: begin
            // cur and v are representatives already
            rep_we = 1'b1; rep_a = cur_ff[AW-1:0]; rep_wd = v_ff[AW-1:0];
            cur_in = aux_ff; st_in = S_COL;
         end
         S_DEP: begin
            if (cur_ff == ROOT || dcnt_ff > NW'(NODES)) begin
               if (ph_ff == P_DU) begin
                  du_in = dcnt_ff; dcnt_in = '0; cur_in = v_ff; ph_in = P_DV;
               end else begin
                  st_in = S_CROSS;
               end
            end else begin
               res_in = cur_ff; ret_in = S_DISP; st_in = S_UP_RD;
            end
         end
         S_CROSS: begin
            if (du_ff < dcnt_ff) begin
               em_in = 1'b1; os_in = 10'(u_ff); od_in = 10'(v_ff);
               st_in = S_DONE;
            end else begin
               res_in = v_ff; ph_in = P_PV; ret_in = S_DISP; st_in = S_UP_RD;
               cur_in = u_ff;
            end
         end
         S_SETP: begin
            // parent of v becomes u (both representatives)
            par_we = 1'b1; par_a = v_ff[AW-1:0]; par_wd = u_ff;
            st_in = S_DONE;
         end
         S_DONE: begin
            out_v_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; cnt_ff <= '0; out_v_ff <= 1'b0;
         ret_ff <= S_IDLE; ph_ff <= P_Q;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; out_v_ff <= out_v_in;
         ret_ff <= ret_in; ph_ff <= ph_in;
      end
      if (st_ff == S_IDLE && start) begin
         d_ff <= req_dst_node;
      end
      x_ff <= x_in; r_ff <= r_in; c_ff <= c_in; res_ff <= res_in;
      u_ff <= u_in; v_ff <= v_in; cur_ff <= cur_in; aux_ff <= aux_in;
      du_ff <= du_in; dcnt_ff <= dcnt_in; hop_ff <= hop_in;
      em_ff <= em_in; ch_ff <= ch_in; os_ff <= os_in; od_ff <= od_in;
      rp_ff <= rp_in;
   end

   assign busy               = (st_ff != S_IDLE);
   assign rsp_strobe         = out_v_ff;
   assign rsp_emit_valid     = em_ff;
   assign rsp_out_src        = os_ff;
   assign rsp_out_dst        = od_ff;
   assign rsp_changed        = ch_ff;
   assign rsp_representative = rp_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held");
   a_busy_res: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");
   a_emit_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_emit_valid |-> rsp_out_src != rsp_out_dst)
      else $error("emitted self loop");
endmodule

/* rtl/sscc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sscc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

/* tb/streaming_scc_edge_step_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_scc_edge_step_top_test
// Checks the streaming SCC edge step against a cycle-free predictor. Directed
// edges and queries cover every edge case. Random traffic then follows on
// small node pools, so that cycles, collapses and cross edges occur often.
// Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module streaming_scc_edge_step_top_test
   import sscc_pkg::*;
;

   localparam int NODES      = 1024;
   localparam int ROOT       = NODES;       // dummy root: no parent
   localparam int STALL_MAX  = 200000;      // cycles with no transaction at all

   typedef struct packed {
      logic       emit_valid;
      logic [9:0] out_src;
      logic [9:0] out_dst;
      logic       changed;
      logic [9:0] representative;
   } scc_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   logic [9:0]  req_src_node;
   logic [9:0]  req_dst_node;
   logic        rsp_strobe;
   logic        rsp_emit_valid;
   logic [9:0]  rsp_out_src;
   logic [9:0]  rsp_out_dst;
   logic        rsp_changed;
   logic [9:0]  rsp_representative;

   // predictor state: forest parents and representative map
   int             forest_parent [0:NODES];
   int             rep_link      [0:NODES-1];
   scc_result_type pending_results [$];
   int             error_count;
   int             idle_pct;
   int             stall_cycles;

   streaming_scc_edge_step_top #(.NODES(NODES)) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_src_node       (req_src_node),
      .req_dst_node       (req_dst_node),
      .rsp_strobe         (rsp_strobe),
      .rsp_emit_valid     (rsp_emit_valid),
      .rsp_out_src        (rsp_out_src),
      .rsp_out_dst        (rsp_out_dst),
      .rsp_changed        (rsp_changed),
      .rsp_representative (rsp_representative)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Find the representative of a node and compress the chain walked.
   function automatic int find_rep(input int x);
      int r, c, nx;
      if (x >= NODES) return ROOT;
      r = x;
      for (int k = 0; k <= NODES && rep_link[r] != r; k++) begin
         r = rep_link[r];
         if (r >= NODES) return ROOT;
      end
      c = x;
      for (int k = 0; k <= NODES && c != r; k++) begin
         nx = rep_link[c];
         rep_link[c] = r;
         if (nx >= NODES) break;
         c = nx;
      end
      return r;
   endfunction

   function automatic int parent_rep(input int x);
      int r;
      r = find_rep(x);
      if (r >= NODES) return ROOT;
      return find_rep(forest_parent[r]);
   endfunction

   function automatic void hang_under(input int x, input int p);
      int r;
      r = find_rep(x);
      if (r < NODES) forest_parent[r] = find_rep(p);
   endfunction

   function automatic bit is_below(input int x, input int target);
      int cur, tg;
      cur = find_rep(x);
      tg  = find_rep(target);
      for (int k = 0; k <= NODES && cur != ROOT; k++) begin
         if (cur == tg) return 1'b1;
         cur = parent_rep(cur);
      end
      return 1'b0;
   endfunction

   function automatic int tree_depth(input int x);
      int cur, d;
      cur = find_rep(x);
      d = 0;
      while (d <= NODES && cur != ROOT) begin
         cur = parent_rep(cur);
         d++;
      end
      return d;
   endfunction

   // Apply one transaction to the forest and return its result.
   function automatic scc_result_type scc_step(input logic cmd, input int s,
                                               input int d);
      scc_result_type res;
      int u, v, cur, nx, pv;
      res = '0;
      if (cmd == CMD_QUERY) begin
         res.representative = (s < NODES) ? 10'(find_rep(s)) : 10'(s);
         return res;
      end
      if (s >= NODES || d >= NODES) return res;
      u = find_rep(s);
      v = find_rep(d);
      if (u == v) return res;
      if (is_below(v, u)) return res;
      if (is_below(u, v)) begin
         // collapse the tree path from u up to v
         cur = u;
         for (int k = 0; k <= NODES && cur != v && cur != ROOT; k++) begin
            nx = parent_rep(cur);
            if (find_rep(cur) < NODES && find_rep(v) < NODES)
               rep_link[find_rep(cur)] = find_rep(v);
            cur = nx;
         end
         res.changed = 1'b1;
         return res;
      end
      if (parent_rep(v) == ROOT) begin
         hang_under(v, u);
         res.changed = 1'b1;
         return res;
      end
      if (tree_depth(u) < tree_depth(v)) begin
         res.emit_valid = 1'b1;
         res.out_src    = 10'(u);
         res.out_dst    = 10'(v);
      end else begin
         pv = parent_rep(v);
         res.emit_valid = 1'b1;
         res.out_src    = 10'(pv);
         res.out_dst    = 10'(v);
         hang_under(v, u);
         res.changed    = 1'b1;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Send one transaction; start stays high so a following one can go back to back.
   task automatic send_item(input logic cmd, input int s, input int d);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_command  <= cmd;
      req_src_node <= s[9:0];
      req_dst_node <= d[9:0];
      // busy is stable between edges; the next rising edge with busy low accepts
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_results.insert(pending_results.size(), scc_step(cmd, s, d));
   endtask

   // Hold the sender off until every expected result is back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      scc_result_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_emit_valid, rsp_out_src, rsp_out_dst, rsp_changed,
                 rsp_representative};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.emit_valid != want.emit_valid) begin
               $display("%0t: emit_valid expected %0d got %0d", $time,
                        want.emit_valid, got.emit_valid);
               error_count++;
            end
            if (got.out_src != want.out_src) begin
               $display("%0t: out_src expected %0d got %0d", $time,
                        want.out_src, got.out_src);
               error_count++;
            end
            if (got.out_dst != want.out_dst) begin
               $display("%0t: out_dst expected %0d got %0d", $time,
                        want.out_dst, got.out_dst);
               error_count++;
            end
            if (got.changed != want.changed) begin
               $display("%0t: changed expected %0d got %0d", $time,
                        want.changed, got.changed);
               error_count++;
            end
            if (got.representative != want.representative) begin
               $display("%0t: representative expected %0d got %0d", $time,
                        want.representative, got.representative);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with neither an accepted request nor a result.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every edge case by construction, plus the field extremes.
   task automatic test_directed();
      send_item(CMD_QUERY, 0, 1023);
      send_item(CMD_QUERY, 1023, 0);
      send_item(CMD_EDGE, 5, 5);        // self loop
      send_item(CMD_EDGE, 1, 2);        // attach 2 under 1
      send_item(CMD_EDGE, 1, 2);        // forward edge
      send_item(CMD_EDGE, 2, 3);        // attach 3 under 2
      send_item(CMD_EDGE, 3, 1);        // backward edge: collapse 3,2 into 1
      send_item(CMD_QUERY, 3, 0);
      send_item(CMD_EDGE, 10, 11);
      send_item(CMD_EDGE, 12, 13);
      send_item(CMD_EDGE, 13, 11);      // cross, equal depth: re-parent
      send_item(CMD_EDGE, 20, 11);      // cross, shallower source: defer
      send_item(CMD_EDGE, 1023, 1022);
      send_item(CMD_EDGE, 1022, 1023);  // backward at the top of the range
      send_item(CMD_EDGE, 0, 1023);
      send_item(CMD_QUERY, 1022, 1023);
      send_item(CMD_EDGE, 1023, 0);
      send_item(CMD_QUERY, 0, 0);
      wait_drained();
   endtask

   // Random edges on a small moving pool of nodes, with some queries.
   task automatic test_random(input int count);
      int base, span, s, d;
      logic cmd;
      base = $urandom_range(0, NODES - 64);
      span = $urandom_range(8, 48);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            base = $urandom_range(0, NODES - 64);
            span = $urandom_range(8, 48);
         end
         cmd = ($urandom_range(0, 99) < 20) ? CMD_QUERY : CMD_EDGE;
         if ($urandom_range(0, 99) < 8) begin
            s = $urandom_range(0, NODES - 1);
            d = $urandom_range(0, NODES - 1);
         end else begin
            s = base + $urandom_range(0, span);
            d = base + $urandom_range(0, span);
         end
         send_item(cmd, s, d);
      end
   endtask

   initial begin
      error_count  = 0;
      idle_pct     = 0;
      stall_cycles = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_command  = CMD_EDGE;
      req_src_node = '0;
      req_dst_node = '0;
      for (int i = 0; i <= NODES; i++) forest_parent[i] = ROOT;
      for (int i = 0; i < NODES; i++)  rep_link[i] = i;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      idle_pct = 23;
      test_random(660);
      wait_drained();
      idle_pct = 76;
      test_random(660);
      wait_drained();
      idle_pct = 0;
      test_random(660);

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
